// File: rtl/gihg_pkg.sv
// ----------------------------------------------------------------------------
// gihg_pkg
// Types and constants shared by the idle hysteresis governor.
// ----------------------------------------------------------------------------
package gihg_pkg;

   localparam int GIHG_MAX_LEVELS = 16;
   localparam int GIHG_ACC_WIDTH  = 40;

   localparam int CSR_ADDR_WIDTH  = 5;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [15:0] NORM_WINDOW_RESET    = 16'd16667;
   localparam logic [15:0] RAMP_THRESHOLD_RESET = 16'd6000;
   localparam logic [5:0]  LAZINESS_LIMIT_RESET = 6'd3;
   localparam logic [3:0]  THERMAL_LEVEL_RESET  = 4'd0;
   localparam logic [4:0]  LEVEL_COUNT_RESET    = 5'd8;

   localparam logic [4:0]  MASK_CAP_THERMAL = 5'd31;
   localparam logic [4:0]  MASK_CAP_NORMAL  = 5'd7;
   localparam logic [31:0] SKIP_WARMUP      = 32'd31;
   localparam logic [3:0]  TOP_LEVEL_CAP    = 4'd15;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_SLEEP  = 1'b1;

   typedef enum logic [2:0] {
      CSR_HOLD_MODE      = 3'd0,
      CSR_NORM_WINDOW    = 3'd1,
      CSR_RAMP_THRESHOLD = 3'd2,
      CSR_LAZINESS_LIMIT = 3'd3,
      CSR_THERMAL_LEVEL  = 3'd4,
      CSR_LEVEL_COUNT    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic        hold_mode;
      logic [15:0] norm_window;
      logic [15:0] ramp_threshold;
      logic [5:0]  laziness_limit;
      logic [3:0]  thermal_level;
      logic [4:0]  level_count;
   } cfg_type;

   typedef struct packed {
      logic        opcode;
      logic [31:0] sample_busy_time;
      logic [31:0] sample_total_time;
      logic [3:0]  current_level;
   } req_item_type;

   typedef struct packed {
      logic signed [1:0] level_step;
      logic [3:0]        new_level;
      logic              decided;
      logic [15:0]       idle_metric;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_EVAL,
      ST_PREP,
      ST_DIVIDE,
      ST_DECIDE,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/gihg_csr.sv
// ----------------------------------------------------------------------------
// gihg_csr
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module gihg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [gihg_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [gihg_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [gihg_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready,
   output gihg_pkg::cfg_type                   cfg
);
   import gihg_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index  = csr_index_type'(paddr[4:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_HOLD_MODE:      cfg_in.hold_mode      = pwdata[0];
            CSR_NORM_WINDOW:    cfg_in.norm_window    = pwdata[15:0];
            CSR_RAMP_THRESHOLD: cfg_in.ramp_threshold = pwdata[15:0];
            CSR_LAZINESS_LIMIT: cfg_in.laziness_limit = pwdata[5:0];
            CSR_THERMAL_LEVEL:  cfg_in.thermal_level  = pwdata[3:0];
            CSR_LEVEL_COUNT:    cfg_in.level_count    = pwdata[4:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (index)
         CSR_HOLD_MODE:      prdata[0]    = cfg_ff.hold_mode;
         CSR_NORM_WINDOW:    prdata[15:0] = cfg_ff.norm_window;
         CSR_RAMP_THRESHOLD: prdata[15:0] = cfg_ff.ramp_threshold;
         CSR_LAZINESS_LIMIT: prdata[5:0]  = cfg_ff.laziness_limit;
         CSR_THERMAL_LEVEL:  prdata[3:0]  = cfg_ff.thermal_level;
         CSR_LEVEL_COUNT:    prdata[4:0]  = cfg_ff.level_count;
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_mode      <= 1'b0;
         cfg_ff.norm_window    <= NORM_WINDOW_RESET;
         cfg_ff.ramp_threshold <= RAMP_THRESHOLD_RESET;
         cfg_ff.laziness_limit <= LAZINESS_LIMIT_RESET;
         cfg_ff.thermal_level  <= THERMAL_LEVEL_RESET;
         cfg_ff.level_count    <= LEVEL_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/gihg_ratio.sv
// ----------------------------------------------------------------------------
// gihg_ratio
// Iterative scaled ratio floor(idle*scale/total), one half step per cycle
// on a shared subtract and compare unit.
// ----------------------------------------------------------------------------
module gihg_ratio #(
   parameter int ACC_WIDTH = gihg_pkg::GIHG_ACC_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [ACC_WIDTH-1:0] idle,
   input  logic [ACC_WIDTH-1:0] total,
   input  logic [15:0]          scale,
   output logic                 done,
   output logic [15:0]          quotient
);
   import gihg_pkg::*;

   logic [ACC_WIDTH-1:0] rem_ff,   rem_in;
   logic [ACC_WIDTH-1:0] idle_ff,  idle_in;
   logic [ACC_WIDTH-1:0] total_ff, total_in;
   logic [15:0]          scale_ff, scale_in;
   logic [15:0]          quot_ff,  quot_in;
   logic [3:0]           bit_ff,   bit_in;
   logic                 phase_b_ff, phase_b_in;
   logic                 run_ff,   run_in;
   logic                 done_ff,  done_in;

   logic [ACC_WIDTH:0]   operand;
   logic [ACC_WIDTH+1:0] diff;
   logic                 ge;

   // phase a doubles the remainder, phase b adds idle where the scale bit is set
   assign operand = phase_b_ff ? ({1'b0, idle_ff} + {1'b0, rem_ff}) : {rem_ff, 1'b0};
   assign diff    = {1'b0, operand} - {2'b00, total_ff};
   assign ge      = ~diff[ACC_WIDTH+1];

   assign done     = done_ff;
   assign quotient = quot_ff;

   always_comb begin
      rem_in     = rem_ff;
      idle_in    = idle_ff;
      total_in   = total_ff;
      scale_in   = scale_ff;
      quot_in    = quot_ff;
      bit_in     = bit_ff;
      phase_b_in = phase_b_ff;
      run_in     = run_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = '0;
         idle_in    = idle;
         total_in   = total;
         scale_in   = scale;
         quot_in    = '0;
         bit_in     = 4'd15;
         phase_b_in = 1'b0;
         run_in     = 1'b1;
      end else if (run_ff) begin
         if (!phase_b_ff) begin
            rem_in     = ge ? diff[ACC_WIDTH-1:0] : operand[ACC_WIDTH-1:0];
            quot_in    = {quot_ff[14:0], ge};
            phase_b_in = 1'b1;
         end else begin
            if (scale_ff[bit_ff]) begin
               rem_in  = ge ? diff[ACC_WIDTH-1:0] : operand[ACC_WIDTH-1:0];
               quot_in = quot_ff + {15'd0, ge};
            end
            phase_b_in = 1'b0;
            if (bit_ff == 4'd0) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end else begin
               bit_in = bit_ff - 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= 1'b0;
         done_ff    <= 1'b0;
         phase_b_ff <= 1'b0;
         bit_ff     <= '0;
      end else begin
         run_ff     <= run_in;
         done_ff    <= done_in;
         phase_b_ff <= phase_b_in;
         bit_ff     <= bit_in;
      end
      rem_ff   <= rem_in;
      idle_ff  <= idle_in;
      total_ff <= total_in;
      scale_ff <= scale_in;
      quot_ff  <= quot_in;
   end

endmodule

// File: rtl/gpu_idle_hysteresis_governor.sv
// ----------------------------------------------------------------------------
// gpu_idle_hysteresis_governor
// Power level governor: accumulates busy and total time, skips samples under
// an adaptive mask, evaluates a scaled idle statistic and steps the level
// through a laziness counter with asymmetric hysteresis.
//
//   channel  direction  handshake                  payload
//   req      in         req_valid / req_stall      req_item (req_item_type)
//   rsp      out        rsp_valid / rsp_stall      rsp_item (rsp_item_type)
//   csr      in/out     csr_psel/penable/pready    csr_paddr, csr_pwdata/prdata
//
// from acceptance to the output register an item passes ST_ACCUM, ST_FINISH
// when held or slept; ST_ACCUM, ST_EVAL, ST_FINISH when empty or skipped;
// ST_ACCUM, ST_EVAL, ST_PREP, ST_DECIDE, ST_FINISH when evaluated, with ST_DIVIDE
// before ST_DECIDE while the ratio unit runs its 16 bit steps; then ST_IDLE.
// req_stall is high from acceptance until the result is in the output
// register; a new item is accepted while that result still waits.
// reset is synchronous and clears control state, counters and CSRs but not item or result data.
// ----------------------------------------------------------------------------
module gpu_idle_hysteresis_governor #(
   parameter int MAX_LEVELS = gihg_pkg::GIHG_MAX_LEVELS,
   parameter int ACC_WIDTH  = gihg_pkg::GIHG_ACC_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  gihg_pkg::req_item_type              req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output gihg_pkg::rsp_item_type              rsp_item,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gihg_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [gihg_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [gihg_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import gihg_pkg::*;

   localparam logic [6:0] MAX_LEVELS_W = 7'(MAX_LEVELS);

   cfg_type cfg;

   state_type            state_ff, state_in;
   req_item_type         item_ff, item_in;
   logic [ACC_WIDTH-1:0] busy_acc_ff, busy_acc_in;
   logic [ACC_WIDTH-1:0] total_acc_ff, total_acc_in;
   logic [31:0]          skip_count_ff, skip_count_in;
   logic [4:0]           mask_ff, mask_in;
   logic signed [7:0]    lazy_ff, lazy_in;
   logic [15:0]          stat_ff, stat_in;
   logic                 decided_ff, decided_in;
   logic signed [1:0]    step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_item_ff, rsp_item_in;

   logic                 div_start;
   logic                 div_done;
   logic [15:0]          div_quot;

   logic [ACC_WIDTH:0]   busy_sum;
   logic [ACC_WIDTH:0]   total_sum;
   logic [31:0]          skip_next;
   logic [4:0]           mask_cap;
   logic [ACC_WIDTH:0]   idle_diff;
   logic [ACC_WIDTH-1:0] idle_val;
   logic                 need_scale;
   logic                 rsp_free;

   logic [5:0]           half;
   logic signed [7:0]    neg_half;
   logic signed [7:0]    limit_s;
   logic [6:0]           count_eff;
   logic signed [7:0]    top;
   logic signed [7:0]    cur_s;
   logic signed [7:0]    lazy_dec;
   logic signed [7:0]    lazy_inc;
   logic signed [1:0]    step_dec;
   logic signed [7:0]    lazy_dec_out;

   gihg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   gihg_ratio #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_ratio (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .idle     (idle_val),
      .total    (total_acc_ff),
      .scale    (cfg.norm_window),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;

   // saturating accumulation
   assign busy_sum  = {1'b0, busy_acc_ff}
                    + {{(ACC_WIDTH-31){1'b0}}, item_ff.sample_busy_time};
   assign total_sum = {1'b0, total_acc_ff}
                    + {{(ACC_WIDTH-31){1'b0}}, item_ff.sample_total_time};

   assign skip_next = skip_count_ff + 32'd1;
   assign mask_cap  = (item_ff.current_level == cfg.thermal_level) ?
                      MASK_CAP_THERMAL : MASK_CAP_NORMAL;

   assign idle_diff  = {1'b0, total_acc_ff} - {1'b0, busy_acc_ff};
   assign idle_val   = idle_diff[ACC_WIDTH] ? '0 : idle_diff[ACC_WIDTH-1:0];
   assign need_scale = total_acc_ff > {{(ACC_WIDTH-16){1'b0}}, cfg.norm_window};

   // hysteresis decision
   always_comb begin
      half     = cfg.laziness_limit >> 1;
      neg_half = -$signed({2'b00, half});
      limit_s  = $signed({2'b00, cfg.laziness_limit});
      count_eff = ({2'b00, cfg.level_count} > MAX_LEVELS_W) ?
                  MAX_LEVELS_W : {2'b00, cfg.level_count};
      top = $signed({1'b0, count_eff}) - 8'sd1;
      if (top > $signed({4'b0000, TOP_LEVEL_CAP})) begin
         top = $signed({4'b0000, TOP_LEVEL_CAP});
      end
      cur_s    = $signed({4'b0000, item_ff.current_level});
      lazy_dec = (lazy_ff > neg_half) ? lazy_ff - 8'sd1 : lazy_ff;
      lazy_inc = (lazy_ff < limit_s) ? lazy_ff + 8'sd1 : lazy_ff;
      step_dec = 2'sd0;
      if (stat_ff < cfg.ramp_threshold) begin
         lazy_dec_out = lazy_dec;
         if (item_ff.current_level > cfg.thermal_level && lazy_dec <= neg_half) begin
            lazy_dec_out = 8'sd0;
            step_dec     = -2'sd1;
         end
      end else begin
         lazy_dec_out = lazy_inc;
         if (cur_s < top && lazy_inc >= limit_s) begin
            lazy_dec_out = 8'sd0;
            step_dec     = 2'sd1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (cfg.hold_mode || item_ff.opcode == OP_SLEEP) state_in = ST_FINISH;
            else state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (total_acc_ff == '0 || (skip_next[4:0] & mask_ff) != 5'd0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = need_scale ? ST_DIVIDE : ST_DECIDE;
         end
         ST_DIVIDE: begin
            if (div_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      item_in       = item_ff;
      busy_acc_in   = busy_acc_ff;
      total_acc_in  = total_acc_ff;
      skip_count_in = skip_count_ff;
      mask_in       = mask_ff;
      lazy_in       = lazy_ff;
      stat_in       = stat_ff;
      decided_in    = decided_ff;
      step_in       = step_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      div_start     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in    = req_item;
               stat_in    = '0;
               decided_in = 1'b0;
               step_in    = 2'sd0;
            end
         end
         ST_ACCUM: begin
            if (!cfg.hold_mode) begin
               if (item_ff.opcode == OP_SLEEP) begin
                  busy_acc_in   = '0;
                  total_acc_in  = '0;
                  skip_count_in = '0;
                  mask_in       = '0;
               end else begin
                  busy_acc_in  = busy_sum[ACC_WIDTH] ? '1 : busy_sum[ACC_WIDTH-1:0];
                  total_acc_in = total_sum[ACC_WIDTH] ? '1 : total_sum[ACC_WIDTH-1:0];
               end
            end
         end
         ST_EVAL: begin
            if (total_acc_ff != '0) begin
               skip_count_in = skip_next;
               if ((skip_next[4:0] & mask_ff) == 5'd0 && skip_next > SKIP_WARMUP
                   && mask_ff < mask_cap) begin
                  mask_in = {mask_ff[3:0], 1'b1};
               end
            end
         end
         ST_PREP: begin
            busy_acc_in  = '0;
            total_acc_in = '0;
            if (need_scale) div_start = 1'b1;
            else stat_in = idle_val[15:0];
         end
         ST_DIVIDE: begin
            if (div_done) stat_in = div_quot;
         end
         ST_DECIDE: begin
            decided_in = 1'b1;
            step_in    = step_dec;
            lazy_in    = lazy_dec_out;
            if (step_dec != 2'sd0) begin
               skip_count_in = '0;
               mask_in       = '0;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.level_step  = step_ff;
               rsp_item_in.new_level   = item_ff.current_level + {{2{step_ff[1]}}, step_ff};
               rsp_item_in.decided     = decided_ff;
               rsp_item_in.idle_metric = stat_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff & rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         busy_acc_ff   <= '0;
         total_acc_ff  <= '0;
         skip_count_ff <= '0;
         mask_ff       <= '0;
         lazy_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_acc_ff   <= busy_acc_in;
         total_acc_ff  <= total_acc_in;
         skip_count_ff <= skip_count_in;
         mask_ff       <= mask_in;
         lazy_ff       <= lazy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff     <= item_in;
      stat_ff     <= stat_in;
      decided_ff  <= decided_in;
      step_ff     <= step_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

// File: tb/governor_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// governor_check_pkg
// Level decision scoreboard for the idle hysteresis governor: keeps its own
// copy of the registers and governor state, predicts the decision for every
// accepted item and compares returned items field by field in order.
// ----------------------------------------------------------------------------
package governor_check_pkg;

   import gihg_pkg::*;

   class level_decision_board;

      typedef logic [GIHG_ACC_WIDTH-1:0] acc_type;

      logic        hold_mode;
      logic [15:0] norm_window;
      logic [15:0] ramp_threshold;
      logic [5:0]  laziness_limit;
      logic [3:0]  thermal_level;
      logic [4:0]  level_count;

      acc_type     busy_sum;
      acc_type     total_sum;
      logic [31:0] sample_count;
      logic [4:0]  gate_mask;
      int          laziness;

      logic [3:0]   level_now;
      rsp_item_type pending_decisions[$];
      int           mismatches;

      function new();
         hold_mode      = 1'b0;
         norm_window    = NORM_WINDOW_RESET;
         ramp_threshold = RAMP_THRESHOLD_RESET;
         laziness_limit = LAZINESS_LIMIT_RESET;
         thermal_level  = THERMAL_LEVEL_RESET;
         level_count    = LEVEL_COUNT_RESET;
         busy_sum       = '0;
         total_sum      = '0;
         sample_count   = '0;
         gate_mask      = '0;
         laziness       = 0;
         level_now      = 4'd3;
         mismatches     = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_HOLD_MODE:      hold_mode      = value[0];
            CSR_NORM_WINDOW:    norm_window    = value[15:0];
            CSR_RAMP_THRESHOLD: ramp_threshold = value[15:0];
            CSR_LAZINESS_LIMIT: laziness_limit = value[5:0];
            CSR_THERMAL_LEVEL:  thermal_level  = value[3:0];
            CSR_LEVEL_COUNT:    level_count    = value[4:0];
            default: ;
         endcase
      endfunction

      function acc_type sat_add(acc_type a, logic [31:0] b);
         logic [GIHG_ACC_WIDTH:0] s;
         s = {1'b0, a} + b;
         return s[GIHG_ACC_WIDTH] ? '1 : s[GIHG_ACC_WIDTH-1:0];
      endfunction

      // hysteresis: busy needs limit/2 samples, idle needs limit samples
      function int level_step_for(logic [15:0] stat, int cur);
         int lim;
         int half;
         int count;
         int top;
         lim   = int'(laziness_limit);
         half  = lim / 2;
         count = int'(level_count);
         if (count > GIHG_MAX_LEVELS) count = GIHG_MAX_LEVELS;
         top = count - 1;
         if (top > int'(TOP_LEVEL_CAP)) top = int'(TOP_LEVEL_CAP);
         if (stat < ramp_threshold) begin
            if (laziness > -half) laziness--;
            if (cur <= int'(thermal_level)) return 0;
            if (laziness <= -half) begin
               laziness = 0;
               return -1;
            end
         end else begin
            if (laziness < lim) laziness++;
            if (cur >= top) return 0;
            if (laziness >= lim) begin
               laziness = 0;
               return 1;
            end
         end
         return 0;
      endfunction

      function void note_sample(req_item_type it);
         rsp_item_type exp;
         logic [63:0]  idle;
         logic [63:0]  stat;
         logic [4:0]   cap;
         int           cur;
         int           step;
         exp           = '0;
         exp.new_level = it.current_level;
         cur           = int'(it.current_level);
         if (!hold_mode) begin
            if (it.opcode == OP_SLEEP) begin
               busy_sum     = '0;
               total_sum    = '0;
               sample_count = '0;
               gate_mask    = '0;
            end else begin
               total_sum = sat_add(total_sum, it.sample_total_time);
               busy_sum  = sat_add(busy_sum, it.sample_busy_time);
               if (total_sum != '0) begin
                  sample_count++;
                  if ((sample_count & {27'd0, gate_mask}) == '0) begin
                     cap = (it.current_level == thermal_level) ? MASK_CAP_THERMAL
                                                               : MASK_CAP_NORMAL;
                     if (sample_count > SKIP_WARMUP && gate_mask < cap)
                        gate_mask = {gate_mask[3:0], 1'b1};
                     idle = (total_sum > busy_sum) ? 64'(total_sum - busy_sum) : 64'd0;
                     if (total_sum > norm_window)
                        stat = (idle * 64'(norm_window)) / 64'(total_sum);
                     else
                        stat = idle;
                     total_sum = '0;
                     busy_sum  = '0;
                     step = level_step_for(stat[15:0], cur);
                     if (step != 0) begin
                        sample_count = '0;
                        gate_mask    = '0;
                     end
                     exp.level_step  = 2'(step);
                     exp.new_level   = 4'(cur + step);
                     exp.decided     = 1'b1;
                     exp.idle_metric = stat[15:0];
                  end
               end
            end
         end
         level_now = exp.new_level;
         pending_decisions.push_back(exp);
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type exp;
         if (pending_decisions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: step %0d level %0d decided %0b stat %0d",
                        got.level_step, got.new_level, got.decided, got.idle_metric);
            return;
         end
         exp = pending_decisions.pop_front();
         if (got.level_step !== exp.level_step || got.new_level !== exp.new_level ||
             got.decided !== exp.decided || got.idle_metric !== exp.idle_metric) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: expected step %0d level %0d decided %0b stat %0d,",
                         " got step %0d level %0d decided %0b stat %0d"},
                        exp.level_step, exp.new_level, exp.decided, exp.idle_metric,
                        got.level_step, got.new_level, got.decided, got.idle_metric);
         end
      endfunction

      function int pending();
         return pending_decisions.size();
      endfunction

   endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the idle hysteresis governor: directed samples, then long
// runs of load-shaped samples that follow the predicted level, under several
// register settings and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

   import gihg_pkg::*;
   import governor_check_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 40;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_item_type              req_item;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_item_type              rsp_item;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   level_decision_board board;
   int send_gap_pct = 0;
   int stall_pct    = 0;
   int cycle_count  = 0;

   gpu_idle_hysteresis_governor uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side: check accepted items, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_item);
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   task automatic set_idling(input int gap_pct, input int hold_pct);
      send_gap_pct = gap_pct;
      stall_pct    = hold_pct;
   endtask

   task automatic send_item(input req_item_type it);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      board.note_sample(it);
   endtask

   task automatic end_items();
      req_valid <= 1'b0;
   endtask

   task automatic settle();
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'(4 * int'(idx));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.write_register(idx, value);
   endtask

   task automatic apply_settings(input int hold, input int scale, input int ramp,
                                 input int lazy, input int thermal, input int count);
      write_csr(CSR_HOLD_MODE, 32'(hold));
      write_csr(CSR_NORM_WINDOW, 32'(scale));
      write_csr(CSR_RAMP_THRESHOLD, 32'(ramp));
      write_csr(CSR_LAZINESS_LIMIT, 32'(lazy));
      write_csr(CSR_THERMAL_LEVEL, 32'(thermal));
      write_csr(CSR_LEVEL_COUNT, 32'(count));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic apply_random_settings();
      apply_settings(0, $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 31));
   endtask

   function automatic req_item_type make_item(input logic op, input logic [31:0] busy,
                                              input logic [31:0] total, input int cur);
      req_item_type it;
      it.opcode            = op;
      it.sample_busy_time  = busy;
      it.sample_total_time = total;
      it.current_level     = 4'(cur);
      return it;
   endfunction

   function automatic logic [31:0] pick_total();
      case ($urandom_range(0, 4))
         0: return $urandom_range(1, 20000);
         1: return $urandom_range(1000, 200000);
         2: return $urandom;
         3: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
         default: return $urandom_range(0, 50);
      endcase
   endfunction

   function automatic logic [31:0] busy_share(input logic [31:0] total, input int pct);
      logic [63:0] b;
      b = (64'(total) * 64'(pct)) / 64'd100;
      return (b > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : b[31:0];
   endfunction

   // load runs: mostly busy, mostly idle or mixed, level follows the decisions
   task automatic run_random(input int count);
      int           run_left;
      int           lo;
      int           hi;
      int           pick;
      req_item_type it;
      run_left = 0;
      lo       = 0;
      hi       = 100;
      for (int n = 0; n < count; n++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(4, 40);
            case ($urandom_range(0, 2))
               0: begin lo = 75; hi = 100; end
               1: begin lo = 0; hi = 30; end
               default: begin lo = 0; hi = 115; end
            endcase
         end
         run_left--;
         pick = $urandom_range(0, 99);
         it.opcode            = OP_SAMPLE;
         it.current_level     = board.level_now;
         it.sample_total_time = pick_total();
         it.sample_busy_time  = busy_share(it.sample_total_time, $urandom_range(lo, hi));
         if (pick < 80) begin
            if ($urandom_range(0, 19) == 0) it.current_level = 4'($urandom_range(0, 15));
         end else if (pick < 87) begin
            it = make_item(OP_SLEEP, $urandom, $urandom, $urandom_range(0, 15));
         end else if (pick < 93) begin
            it.sample_total_time = '0;
            it.sample_busy_time  = $urandom;
         end else begin
            it = make_item(OP_SAMPLE, $urandom, $urandom, $urandom_range(0, 15));
         end
         send_item(it);
      end
   endtask

   // busy time piles up while total stays empty until the accumulator saturates
   task automatic busy_flood();
      repeat (258) send_item(make_item(OP_SAMPLE, 32'hFFFF_FFFF, 32'd0, board.level_now));
      send_item(make_item(OP_SAMPLE, 32'd0, 32'd40000, board.level_now));
   endtask

   initial begin
      board = new();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_item    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_idling(32, 84);

      // directed items under reset values of the registers
      send_item(make_item(OP_SLEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15));
      send_item(make_item(OP_SAMPLE, 32'd0, 32'd0, 0));
      send_item(make_item(OP_SAMPLE, 32'd5, 32'd0, 0));
      send_item(make_item(OP_SAMPLE, 32'd0, 32'd10, 3));
      send_item(make_item(OP_SAMPLE, 32'd20000, 32'd16667, 2));
      send_item(make_item(OP_SAMPLE, 32'd0, 32'd16668, 1));
      send_item(make_item(OP_SAMPLE, 32'd0, 32'hFFFF_FFFF, 7));
      send_item(make_item(OP_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15));
      repeat (3) send_item(make_item(OP_SAMPLE, 32'd0, 32'hFFFF_FFFF, 4));
      send_item(make_item(OP_SAMPLE, 32'd10667, 32'd16667, 5));
      send_item(make_item(OP_SAMPLE, 32'd10668, 32'd16667, 5));
      send_item(make_item(OP_SAMPLE, 32'hAAAA_AAAA, 32'h5555_5555, 10));
      send_item(make_item(OP_SAMPLE, 32'h5555_5555, 32'hAAAA_AAAA, 0));
      send_item(make_item(OP_SLEEP, 32'd0, 32'd0, 0));
      send_item(make_item(OP_SAMPLE, 32'd1, 32'd1, 8));
      send_item(make_item(OP_SAMPLE, 32'd0, 32'd1, 0));
      send_item(make_item(OP_SLEEP, $urandom, $urandom, 6));
      end_items();
      settle();

      apply_settings(0, 16667, 6000, 3, 0, 8);
      run_random(30);
      busy_flood();
      run_random(10);
      end_items();
      settle();

      apply_settings(0, 1, 0, 0, 15, 16);
      run_random(25);
      end_items();
      settle();

      apply_settings(0, 65535, 65535, 63, 0, 1);
      run_random(25);
      end_items();
      settle();

      apply_settings(1, $urandom_range(1, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(1, 16));
      send_item(make_item(OP_SLEEP, 32'd0, 32'd0, 3));
      run_random(15);
      end_items();
      settle();

      set_idling(84, 32);
      apply_settings(0, $urandom_range(1, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 63), $urandom_range(0, 15), 0);
      run_random(25);
      end_items();
      settle();

      apply_settings(0, 16667, 6000, 1, 2, 31);
      run_random(25);
      end_items();
      settle();

      apply_settings(0, $urandom_range(1, 65535), $urandom_range(2000, 12000),
                     $urandom_range(0, 8), $urandom_range(0, 4), $urandom_range(1, 16));
      run_random(25);
      end_items();
      settle();

      set_idling(0, 0);
      repeat (3) begin
         apply_random_settings();
         run_random(30);
         end_items();
         settle();
      end

      if (board.mismatches == 0 && board.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
